### src/deq_pkg.sv
package deq_pkg;

    localparam int DEPTH    = 1024;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int VAL_W    = 64;
    localparam int OP_W     = 3;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 2;

    typedef logic signed [VAL_W-1:0] t_val;
    typedef logic [OP_W-1:0]         t_op;
    typedef logic [ADDR_W-1:0]       t_addr;
    typedef logic [CNT_W-1:0]        t_cnt;
    typedef logic [STATUS_W-1:0]     t_status;

    localparam t_op OP_QUERY      = 3'd0;
    localparam t_op OP_PUSH_FRONT = 3'd1;
    localparam t_op OP_PUSH_BACK  = 3'd2;
    localparam t_op OP_POP_FRONT  = 3'd3;
    localparam t_op OP_POP_BACK   = 3'd4;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_POP_EMPTY = 2'd1;
    localparam t_status ST_PUSH_FULL = 2'd2;

    function automatic t_addr idx_next(input t_addr i);
        return (i == ADDR_W'(DEPTH - 1)) ? '0 : i + ADDR_W'(1);
    endfunction

    function automatic t_addr idx_prev(input t_addr i);
        return (i == '0) ? ADDR_W'(DEPTH - 1) : i - ADDR_W'(1);
    endfunction

endpackage

### src/deq_ram.sv
module deq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/double_ended_queue.sv
// Channel  Direction  Handshake               Payload
// in       request    i_in_valid / o_in_stall  i_op, i_item_value
// out      result     o_out_valid / i_out_stall o_front_value, o_back_value, o_count,
//                                              o_is_empty, o_status
//
// One request per cycle unless stalled; each result is held in the output register.
// Both end values and the entries next to them sit in registers; a pop refills the
// neighbour through the single read port of the ring store, landing next cycle.
// Reset is synchronous and clears pointers, count, refill flags and output valid only;
// no clearing pass. The input stalls while a result waits in the output register under i_out_stall.
module double_ended_queue
    import deq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [OP_W-1:0]     i_op,
    input  logic signed [VAL_W-1:0] i_item_value,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [VAL_W-1:0] o_front_value,
    output logic signed [VAL_W-1:0] o_back_value,
    output logic [COUNT_W-1:0]  o_count,
    output logic                o_is_empty,
    output logic [STATUS_W-1:0] o_status
);

    t_addr   r_head, n_head;
    t_addr   r_tail, n_tail;
    t_cnt    r_count, n_count;
    t_val    r_front, n_front;
    t_val    r_back, n_back;
    t_val    r_f2, n_f2;
    t_val    r_b2, n_b2;
    logic    r_f2_ram, n_f2_ram;
    logic    r_b2_ram, n_b2_ram;
    logic    r_out_valid;
    logic    r_empty;
    t_status r_status, n_status;

    logic    acc;
    t_val    f2;
    t_val    b2;
    t_val    ram_rdata;
    logic    ram_we;
    t_addr   ram_waddr;
    logic    ram_re;
    t_addr   ram_raddr;
    logic    is_full;
    logic    is_zero;
    logic    is_one;
    logic    ge2;
    logic    ge3;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign acc        = i_in_valid && !o_in_stall;

    // neighbour entries come from the store while a refill is pending
    assign f2 = r_f2_ram ? ram_rdata : r_f2;
    assign b2 = r_b2_ram ? ram_rdata : r_b2;

    assign is_full = (r_count == CNT_W'(DEPTH));
    assign is_zero = (r_count == '0);
    assign is_one  = (r_count == CNT_W'(1));
    assign ge2     = (r_count >= CNT_W'(2));
    assign ge3     = (r_count >= CNT_W'(3));

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_front   = r_front;
        n_back    = r_back;
        n_f2      = f2;
        n_b2      = b2;
        n_f2_ram  = 1'b0;
        n_b2_ram  = 1'b0;
        n_status  = ST_OK;
        ram_we    = 1'b0;
        ram_waddr = idx_prev(r_head);
        ram_re    = 1'b0;
        ram_raddr = idx_next(idx_next(r_head));

        unique case (i_op)
            OP_PUSH_FRONT: begin
                if (is_full) begin
                    n_status = ST_PUSH_FULL;
                end else begin
                    ram_we    = acc;
                    ram_waddr = idx_prev(r_head);
                    n_head    = idx_prev(r_head);
                    n_count   = r_count + CNT_W'(1);
                    n_front   = i_item_value;
                    n_f2      = r_front;
                    if (is_zero) begin
                        n_back = i_item_value;
                    end
                    if (is_one) begin
                        n_b2 = i_item_value;
                    end
                end
            end
            OP_PUSH_BACK: begin
                if (is_full) begin
                    n_status = ST_PUSH_FULL;
                end else begin
                    ram_we    = acc;
                    ram_waddr = r_tail;
                    n_tail    = idx_next(r_tail);
                    n_count   = r_count + CNT_W'(1);
                    n_back    = i_item_value;
                    n_b2      = r_back;
                    if (is_zero) begin
                        n_front = i_item_value;
                    end
                    if (is_one) begin
                        n_f2 = i_item_value;
                    end
                end
            end
            OP_POP_FRONT: begin
                if (is_zero) begin
                    n_status = ST_POP_EMPTY;
                end else begin
                    n_head  = idx_next(r_head);
                    n_count = r_count - CNT_W'(1);
                    n_front = f2;
                    // fetch the entry that becomes the new neighbour
                    if (ge3) begin
                        ram_re    = acc;
                        ram_raddr = idx_next(idx_next(r_head));
                        n_f2_ram  = 1'b1;
                    end
                end
            end
            OP_POP_BACK: begin
                if (is_zero) begin
                    n_status = ST_POP_EMPTY;
                end else begin
                    n_tail  = idx_prev(r_tail);
                    n_count = r_count - CNT_W'(1);
                    n_back  = b2;
                    if (ge3) begin
                        ram_re    = acc;
                        ram_raddr = idx_prev(idx_prev(idx_prev(r_tail)));
                        n_b2_ram  = 1'b1;
                    end
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase

        // an empty queue reports zero at both ends
        if (n_count == '0) begin
            n_front = '0;
            n_back  = '0;
        end
        if (!ge2 && (n_count == CNT_W'(2))) begin
            n_f2 = n_back;
            n_b2 = n_front;
        end
    end

    deq_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_item_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_f2_ram    <= 1'b0;
            r_b2_ram    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_head      <= n_head;
                r_tail      <= n_tail;
                r_count     <= n_count;
                r_f2_ram    <= n_f2_ram;
                r_b2_ram    <= n_b2_ram;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_front  <= n_front;
            r_back   <= n_back;
            r_f2     <= n_f2;
            r_b2     <= n_b2;
            r_empty  <= (n_count == '0);
            r_status <= n_status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_front_value = r_front;
    assign o_back_value  = r_back;
    assign o_count       = COUNT_W'(r_count);
    assign o_is_empty    = r_empty;
    assign o_status      = r_status;

endmodule

### sim/tb.sv
`timescale 1ns / 100ps

module tb;
    import deq_pkg::*;

    localparam int   CLK_HALF    = 5;
    localparam int   RESET_CYCLES = 8;
    localparam int   LONG_HOLD   = 300;
    localparam int   SETTLE_CYCLES = 10;
    localparam int   CYCLE_LIMIT = 100000;
    localparam int   MAX_REPORTS = 10;

    localparam t_val VMAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam t_val VMIN  = 64'sh8000_0000_0000_0000;
    localparam t_val PAT_A = 64'sh5555_5555_5555_5555;
    localparam t_val PAT_B = 64'shAAAA_AAAA_AAAA_AAAA;

    // op codes the block treats as a plain query
    localparam t_op OP_RSVD_5 = 3'd5;
    localparam t_op OP_RSVD_6 = 3'd6;
    localparam t_op OP_RSVD_7 = 3'd7;

    localparam int DIR_ROWS = 24;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    typedef struct packed {
        t_val                 front;
        t_val                 back;
        logic [COUNT_W-1:0]   count;
        logic                 is_empty;
        t_status              status;
    } t_deq_result;

    typedef struct packed {
        t_op          op;
        t_val         value;
        logic         typed;
        t_deq_result  want;
    } t_dir_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [OP_W-1:0]      i_op;
    logic signed [VAL_W-1:0] i_item_value;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic signed [VAL_W-1:0] o_front_value;
    logic signed [VAL_W-1:0] o_back_value;
    logic [COUNT_W-1:0]   o_count;
    logic                 o_is_empty;
    logic [STATUS_W-1:0]  o_status;

    double_ended_queue i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_item_value  (i_item_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_front_value (o_front_value),
        .o_back_value  (o_back_value),
        .o_count       (o_count),
        .o_is_empty    (o_is_empty),
        .o_status      (o_status)
    );

    // predictor state
    t_val        deque_mem [DEPTH];
    int unsigned deque_head;
    int unsigned deque_tail;
    int unsigned deque_fill;

    t_deq_result expected_results [$];
    t_idle_mode  idle_mode;
    logic        hold_off_req;
    logic        hold_armed;
    int          hold_left;
    int          cycle_cnt = 0;
    int          mismatches = 0;
    int          requests_sent;
    int          results_checked = 0;
    int          peak_fill;
    int          push_full_cnt;
    int          pop_empty_cnt;

    initial begin
        i_clk = 1'b0;
        forever begin
            #CLK_HALF i_clk = ~i_clk;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    function automatic t_deq_result outcome(input t_val f, input t_val b, input int cnt,
                                            input t_status st);
        t_deq_result r;
        r.front    = f;
        r.back     = b;
        r.count    = COUNT_W'(cnt);
        r.is_empty = (cnt == 0);
        r.status   = st;
        return r;
    endfunction

    function automatic t_dir_row known(input t_op op, input t_val v, input t_deq_result e);
        t_dir_row r;
        r.op    = op;
        r.value = v;
        r.typed = 1'b1;
        r.want  = e;
        return r;
    endfunction

    function automatic t_dir_row open_row(input t_op op, input t_val v);
        t_dir_row r;
        r.op    = op;
        r.value = v;
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    function automatic void clear_deque();
        deque_head = 0;
        deque_tail = 0;
        deque_fill = 0;
    endfunction

    function automatic t_deq_result predict_deque(input t_op op, input t_val v);
        t_deq_result r;
        t_status     st;
        st = ST_OK;
        case (op)
            OP_PUSH_FRONT: begin
                if (deque_fill >= DEPTH) begin
                    st = ST_PUSH_FULL;
                end else begin
                    deque_head = (deque_head + DEPTH - 1) % DEPTH;
                    deque_mem[deque_head] = v;
                    deque_fill++;
                end
            end
            OP_PUSH_BACK: begin
                if (deque_fill >= DEPTH) begin
                    st = ST_PUSH_FULL;
                end else begin
                    deque_mem[deque_tail] = v;
                    deque_tail = (deque_tail + 1) % DEPTH;
                    deque_fill++;
                end
            end
            OP_POP_FRONT: begin
                if (deque_fill == 0) begin
                    st = ST_POP_EMPTY;
                end else begin
                    deque_head = (deque_head + 1) % DEPTH;
                    deque_fill--;
                end
            end
            OP_POP_BACK: begin
                if (deque_fill == 0) begin
                    st = ST_POP_EMPTY;
                end else begin
                    deque_tail = (deque_tail + DEPTH - 1) % DEPTH;
                    deque_fill--;
                end
            end
            default: begin
            end
        endcase
        if (st == ST_PUSH_FULL) push_full_cnt++;
        if (st == ST_POP_EMPTY) pop_empty_cnt++;
        if (deque_fill > peak_fill) peak_fill = deque_fill;
        if (deque_fill == 0) begin
            r = outcome('0, '0, 0, st);
        end else begin
            r = outcome(deque_mem[deque_head], deque_mem[(deque_tail + DEPTH - 1) % DEPTH],
                        deque_fill, st);
        end
        return r;
    endfunction

    function automatic int sender_gap_pct(input t_idle_mode m);
        return (m == IDLE_SENDER) ? 45 : (m == IDLE_BOTH) ? 8 : 0;
    endfunction

    function automatic int receiver_stall_pct(input t_idle_mode m);
        return (m == IDLE_RECEIVER) ? 45 : (m == IDLE_BOTH) ? 8 : 0;
    endfunction

    function automatic t_val rand_value();
        int r;
        r = $urandom_range(15);
        if (r == 0) return VMAX;
        if (r == 1) return VMIN;
        if (r == 2) return t_val'(-1);
        if (r == 3) return '0;
        return t_val'({$urandom(), $urandom()});
    endfunction

    function automatic t_op rand_op(input int push_pct, input int pop_pct);
        int r;
        r = $urandom_range(99);
        if (r < push_pct) return ($urandom_range(1) != 0) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        if (r < push_pct + pop_pct) return ($urandom_range(1) != 0) ? OP_POP_BACK : OP_POP_FRONT;
        return t_op'($urandom_range(7));
    endfunction

    // valid stays high into the next request unless a gap is drawn
    task automatic send_request(input t_op op, input t_val v, input logic typed,
                                input t_deq_result want);
        t_deq_result pred;
        idle_mode = t_idle_mode'((requests_sent / 50) % 4);
        while ($urandom_range(99) < sender_gap_pct(idle_mode)) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_item_value <= v;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pred = predict_deque(op, v);
        expected_results.push_back(typed ? want : pred);
        requests_sent++;
    endtask

    task automatic run_mix(input int n, input int push_pct, input int pop_pct);
        repeat (n) send_request(rand_op(push_pct, pop_pct), rand_value(), 1'b0, '0);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // receiver: random stall per mode, or one long counted hold-off on request
    initial begin
        i_out_stall = 1'b0;
        hold_left   = 0;
        hold_armed  = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req && !hold_armed) begin
                hold_armed = 1'b1;
                hold_left  = LONG_HOLD;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(99) < receiver_stall_pct(idle_mode));
            end
        end
    end

    always @(posedge i_clk) begin
        t_deq_result got;
        t_deq_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = outcome(o_front_value, o_back_value, 0, o_status);
            got.count    = o_count;
            got.is_empty = o_is_empty;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: front %0d back %0d count %0d empty %0b st %0d",
                             got.front, got.back, got.count, got.is_empty, got.status);
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (got.front !== want.front || got.back !== want.back ||
                        got.count !== want.count || got.is_empty !== want.is_empty ||
                        got.status !== want.status) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("mismatch on result %0d:", results_checked);
                        $display("  expected front %0d back %0d count %0d empty %0b st %0d",
                                 want.front, want.back, want.count, want.is_empty, want.status);
                        $display("  actual   front %0d back %0d count %0d empty %0b st %0d",
                                 got.front, got.back, got.count, got.is_empty, got.status);
                    end
                end
            end
        end
    end

    initial begin
        t_dir_row dir_rows [DIR_ROWS];
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_op         = OP_QUERY;
        i_item_value = '0;
        hold_off_req = 1'b0;
        idle_mode    = IDLE_NONE;
        requests_sent   = 0;
        peak_fill     = 0;
        push_full_cnt = 0;
        pop_empty_cnt = 0;
        clear_deque();

        dir_rows = '{
            known(OP_QUERY, '0, outcome('0, '0, 0, ST_OK)),
            known(OP_POP_FRONT, '0, outcome('0, '0, 0, ST_POP_EMPTY)),
            known(OP_POP_BACK, VMAX, outcome('0, '0, 0, ST_POP_EMPTY)),
            known(OP_PUSH_FRONT, VMAX, outcome(VMAX, VMAX, 1, ST_OK)),
            known(OP_PUSH_BACK, VMIN, outcome(VMAX, VMIN, 2, ST_OK)),
            known(OP_PUSH_FRONT, t_val'(-1), outcome(t_val'(-1), VMIN, 3, ST_OK)),
            known(OP_PUSH_BACK, '0, outcome(t_val'(-1), '0, 4, ST_OK)),
            open_row(OP_RSVD_5, PAT_A),
            open_row(OP_RSVD_6, PAT_B),
            open_row(OP_RSVD_7, VMIN),
            known(OP_POP_BACK, '0, outcome(t_val'(-1), VMIN, 3, ST_OK)),
            known(OP_POP_FRONT, '0, outcome(VMAX, VMIN, 2, ST_OK)),
            known(OP_POP_FRONT, '0, outcome(VMIN, VMIN, 1, ST_OK)),
            known(OP_POP_BACK, '0, outcome('0, '0, 0, ST_OK)),
            known(OP_POP_BACK, '0, outcome('0, '0, 0, ST_POP_EMPTY)),
            open_row(OP_PUSH_BACK, PAT_A),
            open_row(OP_PUSH_FRONT, PAT_B),
            open_row(OP_PUSH_BACK, t_val'(1)),
            open_row(OP_QUERY, VMAX),
            open_row(OP_POP_FRONT, '0),
            open_row(OP_POP_BACK, '0),
            open_row(OP_POP_FRONT, '0),
            known(OP_POP_FRONT, '0, outcome('0, '0, 0, ST_POP_EMPTY)),
            known(OP_QUERY, VMIN, outcome('0, '0, 0, ST_OK))
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            send_request(dir_rows[i].op, dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);

        // mostly near empty: pops on empty and wrap at index zero
        run_mix(200, 45, 45);
        wait_drained();

        // hold the output for a long stretch while requests keep coming
        hold_off_req = 1'b1;
        run_mix(40, 50, 40);
        wait_drained();

        // fill to the brim, then hover at full and drain part of it
        while (deque_fill < DEPTH) send_request(rand_op(93, 4), rand_value(), 1'b0, '0);
        run_mix(40, 60, 30);
        run_mix(300, 20, 70);

        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("%0d requests sent, %0d results checked, %0d mismatches",
                 requests_sent, results_checked, mismatches);
        $display("peak fill %0d of %0d, %0d pushes on full, %0d pops on empty",
                 peak_fill, DEPTH, push_full_cnt, pop_empty_cnt);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
